/* src/dksg_pkg.sv */
package dksg_pkg;

	localparam int LevelW = 18;
	localparam int SpanW  = 24;
	localparam int TimeW  = 48;
	localparam int AxisW  = 16;
	localparam int AddrW  = 5;
	localparam int DataW  = 32;

	localparam int ShakeSecondGapUs = 120000;

	localparam logic [LevelW-1:0] ShakeBurstRst = LevelW'(24000);
	localparam logic [LevelW-1:0] ShakeQuietRst = LevelW'(10000);
	localparam logic [LevelW-1:0] KnockBurstRst = LevelW'(28000);
	localparam logic [LevelW-1:0] KnockQuietRst = LevelW'(12000);
	localparam logic [SpanW-1:0]  CooldownRst   = SpanW'(600000);
	localparam logic [SpanW-1:0]  ShakeWinRst   = SpanW'(1500000);
	localparam logic [SpanW-1:0]  KnockGapRst   = SpanW'(100000);
	localparam logic [SpanW-1:0]  KnockWinRst   = SpanW'(550000);

	typedef enum logic [2:0] {
		REG_SHAKE_BURST = 3'd0,
		REG_SHAKE_QUIET = 3'd1,
		REG_KNOCK_BURST = 3'd2,
		REG_KNOCK_QUIET = 3'd3,
		REG_COOLDOWN    = 3'd4,
		REG_SHAKE_WIN   = 3'd5,
		REG_KNOCK_GAP   = 3'd6,
		REG_KNOCK_WIN   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FIRST = 2'd1,
		PH_QUIET = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		G_NONE   = 2'd0,
		G_KNOCK  = 2'd1,
		G_NEXT   = 2'd2,
		G_TOGGLE = 2'd3
	} gesture_t;

	typedef struct packed {
		logic [LevelW-1:0] shake_burst_level;
		logic [LevelW-1:0] shake_quiet_level;
		logic [LevelW-1:0] knock_burst_level;
		logic [LevelW-1:0] knock_quiet_level;
		logic [SpanW-1:0]  cooldown_us;
		logic [SpanW-1:0]  shake_window_us;
		logic [SpanW-1:0]  knock_min_gap_us;
		logic [SpanW-1:0]  knock_window_us;
	} cfg_t;

endpackage

/* src/dksg_regs.sv */
module dksg_regs
	import dksg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shake_burst_level <= ShakeBurstRst;
			cfg_q.shake_quiet_level <= ShakeQuietRst;
			cfg_q.knock_burst_level <= KnockBurstRst;
			cfg_q.knock_quiet_level <= KnockQuietRst;
			cfg_q.cooldown_us       <= CooldownRst;
			cfg_q.shake_window_us   <= ShakeWinRst;
			cfg_q.knock_min_gap_us  <= KnockGapRst;
			cfg_q.knock_window_us   <= KnockWinRst;
		end else if (wr_en) begin
			unique case (idx)
				REG_SHAKE_BURST: cfg_q.shake_burst_level <= pwdata[LevelW-1:0];
				REG_SHAKE_QUIET: cfg_q.shake_quiet_level <= pwdata[LevelW-1:0];
				REG_KNOCK_BURST: cfg_q.knock_burst_level <= pwdata[LevelW-1:0];
				REG_KNOCK_QUIET: cfg_q.knock_quiet_level <= pwdata[LevelW-1:0];
				REG_COOLDOWN:    cfg_q.cooldown_us       <= pwdata[SpanW-1:0];
				REG_SHAKE_WIN:   cfg_q.shake_window_us   <= pwdata[SpanW-1:0];
				REG_KNOCK_GAP:   cfg_q.knock_min_gap_us  <= pwdata[SpanW-1:0];
				REG_KNOCK_WIN:   cfg_q.knock_window_us   <= pwdata[SpanW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SHAKE_BURST: prdata = DataW'(cfg_q.shake_burst_level);
			REG_SHAKE_QUIET: prdata = DataW'(cfg_q.shake_quiet_level);
			REG_KNOCK_BURST: prdata = DataW'(cfg_q.knock_burst_level);
			REG_KNOCK_QUIET: prdata = DataW'(cfg_q.knock_quiet_level);
			REG_COOLDOWN:    prdata = DataW'(cfg_q.cooldown_us);
			REG_SHAKE_WIN:   prdata = DataW'(cfg_q.shake_window_us);
			REG_KNOCK_GAP:   prdata = DataW'(cfg_q.knock_min_gap_us);
			REG_KNOCK_WIN:   prdata = DataW'(cfg_q.knock_window_us);
			default:         prdata = '0;
		endcase
	end

endmodule

/* src/dksg_core.sv */
module dksg_core
	import dksg_pkg::*;
#(
	parameter int SHAKE_SECOND_GAP_US = ShakeSecondGapUs
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic signed [AxisW-1:0] x,
	input  logic signed [AxisW-1:0] y,
	input  logic signed [AxisW-1:0] z,
	input  logic [TimeW-1:0]        now,
	input  logic                    cards,
	input  cfg_t                    cfg,
	output gesture_t                gesture_d,
	output logic [LevelW-1:0]       motion_d
);

	localparam logic [TimeW-1:0] SecondGap = TimeW'(SHAKE_SECOND_GAP_US);

	logic signed [AxisW-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic                    base_q;
	phase_t                  knock_q, knock_n;
	phase_t                  shake_q, shake_n;
	logic [TimeW-1:0]        kstart_q, kstart_n;
	logic [TimeW-1:0]        sstart_q, sstart_n;
	logic [TimeW-1:0]        squiet_q, squiet_n;
	logic [TimeW-1:0]        last_q, last_n;

	logic signed [AxisW:0]   dx, dy, dz;
	logic [AxisW:0]          ax, ay, az;
	logic [LevelW-1:0]       motion;

	logic [TimeW-1:0]        dt_k, dt_s, dt_q, dt_l;
	logic k_burst, k_quiet, k_exp, k_gap_ok, knock_hit;
	logic s_burst, s_quiet, s_exp, s_gap_ok, cooling, shake_run, shake_hit;

	assign dx = {x[AxisW-1], x} - {prev_x_q[AxisW-1], prev_x_q};
	assign dy = {y[AxisW-1], y} - {prev_y_q[AxisW-1], prev_y_q};
	assign dz = {z[AxisW-1], z} - {prev_z_q[AxisW-1], prev_z_q};
	assign ax = dx[AxisW] ? (AxisW+1)'(-dx) : (AxisW+1)'(dx);
	assign ay = dy[AxisW] ? (AxisW+1)'(-dy) : (AxisW+1)'(dy);
	assign az = dz[AxisW] ? (AxisW+1)'(-dz) : (AxisW+1)'(dz);
	assign motion = LevelW'(ax) + LevelW'(ay) + LevelW'(az);

	// elapsed times wrap mod 2^48
	assign dt_k = now - kstart_q;
	assign dt_s = now - sstart_q;
	assign dt_q = now - squiet_q;
	assign dt_l = now - last_q;

	assign k_burst  = motion >= cfg.knock_burst_level;
	assign k_quiet  = motion <  cfg.knock_quiet_level;
	assign k_exp    = dt_k > TimeW'(cfg.knock_window_us);
	assign k_gap_ok = dt_k >= TimeW'(cfg.knock_min_gap_us);
	assign s_burst  = motion >= cfg.shake_burst_level;
	assign s_quiet  = motion <  cfg.shake_quiet_level;
	assign s_exp    = dt_s > TimeW'(cfg.shake_window_us);
	assign s_gap_ok = dt_q >= SecondGap;
	assign cooling  = dt_l < TimeW'(cfg.cooldown_us);

	assign knock_hit = base_q && cards && (knock_q == PH_QUIET) && !k_exp && k_burst && k_gap_ok;
	// shake machine sees the sample only with the knock side idle and out of cooldown
	assign shake_run = base_q && !knock_hit && (knock_n == PH_IDLE) && !cooling;
	assign shake_hit = shake_run && (shake_q == PH_QUIET) && !s_exp && s_burst && s_gap_ok;

	// knock next state
	always_comb begin
		knock_n  = knock_q;
		kstart_n = kstart_q;
		if (!cards) begin
			knock_n = PH_IDLE;
		end else begin
			unique case (knock_q)
				PH_IDLE: begin
					if (k_burst) begin
						knock_n  = PH_FIRST;
						kstart_n = now;
					end
				end
				PH_FIRST: begin
					if (k_exp) begin
						knock_n = PH_IDLE;
					end else if (k_quiet) begin
						knock_n = PH_QUIET;
					end
				end
				default: begin
					if (k_exp || knock_hit) begin
						knock_n = PH_IDLE;
					end
				end
			endcase
		end
	end

	// shake next state and action time
	always_comb begin
		shake_n  = shake_q;
		sstart_n = sstart_q;
		squiet_n = squiet_q;
		last_n   = last_q;
		if (knock_hit) begin
			last_n = now;
		end else if (knock_n != PH_IDLE) begin
			shake_n = PH_IDLE;
		end else if (shake_run) begin
			unique case (shake_q)
				PH_IDLE: begin
					if (s_burst) begin
						shake_n  = PH_FIRST;
						sstart_n = now;
					end
				end
				PH_FIRST: begin
					if (s_exp) begin
						shake_n = PH_IDLE;
					end else if (s_quiet) begin
						shake_n  = PH_QUIET;
						squiet_n = now;
					end
				end
				default: begin
					if (s_exp) begin
						shake_n = PH_IDLE;
					end else if (shake_hit) begin
						shake_n = PH_IDLE;
						last_n  = now;
					end
				end
			endcase
		end
	end

	always_comb begin
		motion_d = base_q ? motion : '0;
		if (knock_hit) begin
			gesture_d = G_KNOCK;
		end else if (shake_hit) begin
			gesture_d = cards ? G_NEXT : G_TOGGLE;
		end else begin
			gesture_d = G_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			base_q   <= 1'b0;
			knock_q  <= PH_IDLE;
			shake_q  <= PH_IDLE;
			kstart_q <= '0;
			sstart_q <= '0;
			squiet_q <= '0;
			last_q   <= '0;
		end else if (fire) begin
			prev_x_q <= x;
			prev_y_q <= y;
			prev_z_q <= z;
			base_q   <= 1'b1;
			if (base_q) begin
				knock_q  <= knock_n;
				shake_q  <= shake_n;
				kstart_q <= kstart_n;
				sstart_q <= sstart_n;
				squiet_q <= squiet_n;
				last_q   <= last_n;
			end
		end
	end

	a_prime_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!base_q |-> (gesture_d == G_NONE && motion_d == '0))
		else $error("priming sample produced a result");

	a_knock_clears_shake: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && base_q && knock_n != PH_IDLE) |=> (shake_q == PH_IDLE))
		else $error("shake machine active while knock pending");

	a_action_time: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && gesture_d != G_NONE) |=> (last_q == $past(now)))
		else $error("action time not recorded");

endmodule

/* src/double_knock_shake_gesture_detector_top.sv */
// Pipeline: a sample is registered in the input register, and its result is
// registered in the output register when the input register advances.
// Throughput: one sample per cycle; the input register advances whenever the
// output register is empty or its result is being transferred.
// Reset: arst_n clears the pipeline valids, detector state and baseline, and
// loads the configuration registers with their defaults. The first sample primes.
module double_knock_shake_gesture_detector_top
	import dksg_pkg::*;
#(
	parameter int SHAKE_SECOND_GAP_US = ShakeSecondGapUs
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [AddrW-1:0]        paddr,
	input  logic [DataW-1:0]        pwdata,
	output logic [DataW-1:0]        prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [AxisW-1:0] accel_x,
	input  logic signed [AxisW-1:0] accel_y,
	input  logic signed [AxisW-1:0] accel_z,
	input  logic [TimeW-1:0]        time_us,
	input  logic                    cards_active,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              gesture,
	output logic [LevelW-1:0]       motion
);

	cfg_t                    cfg;
	logic                    valid_s1;
	logic signed [AxisW-1:0] x_s1, y_s1, z_s1;
	logic [TimeW-1:0]        t_s1;
	logic                    cards_s1;
	logic                    advance, fire;
	gesture_t                gesture_d, gesture_q;
	logic [LevelW-1:0]       motion_d, motion_q;
	logic                    out_valid_q;

	dksg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			x_s1     <= accel_x;
			y_s1     <= accel_y;
			z_s1     <= accel_z;
			t_s1     <= time_us;
			cards_s1 <= cards_active;
		end
	end

	dksg_core #(
		.SHAKE_SECOND_GAP_US(SHAKE_SECOND_GAP_US)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.x        (x_s1),
		.y        (y_s1),
		.z        (z_s1),
		.now      (t_s1),
		.cards    (cards_s1),
		.cfg      (cfg),
		.gesture_d(gesture_d),
		.motion_d (motion_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			gesture_q <= gesture_d;
			motion_q  <= motion_d;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;
	assign motion    = motion_q;

	a_knock_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && gesture_q == G_KNOCK) |-> (motion_q >= cfg.knock_burst_level))
		else $error("knock confirm below knock level");

	a_shake_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (gesture_q == G_NEXT || gesture_q == G_TOGGLE))
		|-> (motion_q >= cfg.shake_burst_level))
		else $error("shake action below burst level");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !valid_s1) |=> !out_valid_q)
		else $error("result repeated after transfer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !fire)
		else $error("pending result overwritten");

endmodule

/* verif/dksg_checker.sv */
`timescale 1ns / 100ps

module dksg_checker
	import dksg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic                    pready,
	input  logic [AddrW-1:0]        paddr,
	input  logic [DataW-1:0]        pwdata,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic signed [AxisW-1:0] accel_x,
	input  logic signed [AxisW-1:0] accel_y,
	input  logic signed [AxisW-1:0] accel_z,
	input  logic [TimeW-1:0]        time_us,
	input  logic                    cards_active,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [1:0]              gesture,
	input  logic [LevelW-1:0]       motion,
	output int                      mismatches,
	output int                      outstanding
);

	typedef struct packed {
		gesture_t          gesture;
		logic [LevelW-1:0] motion;
	} gesture_result_t;

	cfg_t                    cfg;
	logic signed [AxisW-1:0] last_x, last_y, last_z;
	logic                    primed;
	phase_t                  knock_ph, shake_ph;
	logic [TimeW-1:0]        knock_t0, shake_t0, shake_tq, action_t;
	gesture_result_t         expected_q[$];
	gesture_result_t         new_res, want_res;
	int                      result_no;

	function automatic int unsigned axis_delta(logic signed [AxisW-1:0] a,
			logic signed [AxisW-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	task automatic detect_gesture(input logic signed [AxisW-1:0] x, y, z,
			input logic [TimeW-1:0] now, input logic cards,
			output gesture_result_t res);
		int unsigned      sum;
		logic [TimeW-1:0] dt;
		logic [TimeW-1:0] since;
		logic [TimeW-1:0] quiet_gap;
		logic             confirmed;
		res.gesture = G_NONE;
		res.motion = '0;
		confirmed = 1'b0;
		if (!primed) begin
			// first sample only sets the baseline
			primed = 1'b1;
		end else begin
			sum = axis_delta(x, last_x) + axis_delta(y, last_y) + axis_delta(z, last_z);
			res.motion = sum[LevelW-1:0];
			if (!cards) begin
				knock_ph = PH_IDLE;
			end else begin
				dt = now - knock_t0;
				case (knock_ph)
					PH_IDLE: begin
						if (sum >= cfg.knock_burst_level) begin
							knock_ph = PH_FIRST;
							knock_t0 = now;
						end
					end
					PH_FIRST: begin
						if (dt > cfg.knock_window_us)
							knock_ph = PH_IDLE;
						else if (sum < cfg.knock_quiet_level)
							knock_ph = PH_QUIET;
					end
					default: begin
						if (dt > cfg.knock_window_us) begin
							knock_ph = PH_IDLE;
						end else if (sum >= cfg.knock_burst_level &&
								dt >= cfg.knock_min_gap_us) begin
							action_t = now;
							knock_ph = PH_IDLE;
							res.gesture = G_KNOCK;
							confirmed = 1'b1;
						end
					end
				endcase
			end
			if (!confirmed) begin
				since = now - action_t;
				if (knock_ph != PH_IDLE) begin
					shake_ph = PH_IDLE;
				end else if (since >= cfg.cooldown_us) begin
					dt = now - shake_t0;
					quiet_gap = now - shake_tq;
					case (shake_ph)
						PH_IDLE: begin
							if (sum >= cfg.shake_burst_level) begin
								shake_ph = PH_FIRST;
								shake_t0 = now;
							end
						end
						PH_FIRST: begin
							if (dt > cfg.shake_window_us) begin
								shake_ph = PH_IDLE;
							end else if (sum < cfg.shake_quiet_level) begin
								shake_ph = PH_QUIET;
								shake_tq = now;
							end
						end
						default: begin
							if (dt > cfg.shake_window_us) begin
								shake_ph = PH_IDLE;
							end else if (sum >= cfg.shake_burst_level &&
									quiet_gap >= TimeW'(ShakeSecondGapUs)) begin
								action_t = now;
								shake_ph = PH_IDLE;
								res.gesture = cards ? G_NEXT : G_TOGGLE;
							end
						end
					endcase
				end
			end
		end
		last_x = x;
		last_y = y;
		last_z = z;
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR result %0d: %s, got gesture %0d motion %0d",
				result_no, what, gesture, motion);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{ShakeBurstRst, ShakeQuietRst, KnockBurstRst, KnockQuietRst,
				CooldownRst, ShakeWinRst, KnockGapRst, KnockWinRst};
			last_x = '0;
			last_y = '0;
			last_z = '0;
			primed = 1'b0;
			knock_ph = PH_IDLE;
			shake_ph = PH_IDLE;
			knock_t0 = '0;
			shake_t0 = '0;
			shake_tq = '0;
			action_t = '0;
			expected_q.delete();
			mismatches = 0;
			outstanding = 0;
			result_no = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[AddrW-1:2]))
					REG_SHAKE_BURST: cfg.shake_burst_level = pwdata[LevelW-1:0];
					REG_SHAKE_QUIET: cfg.shake_quiet_level = pwdata[LevelW-1:0];
					REG_KNOCK_BURST: cfg.knock_burst_level = pwdata[LevelW-1:0];
					REG_KNOCK_QUIET: cfg.knock_quiet_level = pwdata[LevelW-1:0];
					REG_COOLDOWN:    cfg.cooldown_us = pwdata[SpanW-1:0];
					REG_SHAKE_WIN:   cfg.shake_window_us = pwdata[SpanW-1:0];
					REG_KNOCK_GAP:   cfg.knock_min_gap_us = pwdata[SpanW-1:0];
					REG_KNOCK_WIN:   cfg.knock_window_us = pwdata[SpanW-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				result_no++;
				if (expected_q.size() == 0) begin
					note_mismatch("no result expected");
				end else begin
					want_res = expected_q.pop_front();
					if (gesture !== want_res.gesture || motion !== want_res.motion)
						note_mismatch($sformatf("expected gesture %0d motion %0d",
							want_res.gesture, want_res.motion));
				end
			end
			if (in_valid && !in_stall) begin
				detect_gesture(accel_x, accel_y, accel_z, time_us, cards_active, new_res);
				expected_q.push_back(new_res);
			end
			outstanding = expected_q.size();
		end
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import dksg_pkg::*;

	localparam int MaxStep   = 98301;   // largest motion the axis stepper can make
	localparam int IdleLimit = 5000;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [AddrW-1:0]        paddr = '0;
	logic [DataW-1:0]        pwdata = '0;
	logic [DataW-1:0]        prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [AxisW-1:0] accel_x = '0;
	logic signed [AxisW-1:0] accel_y = '0;
	logic signed [AxisW-1:0] accel_z = '0;
	logic [TimeW-1:0]        time_us = '0;
	logic                    cards_active = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [1:0]              gesture;
	logic [LevelW-1:0]       motion;
	int                      mismatches;
	int                      outstanding;

	cfg_t                    cur_cfg;
	logic signed [AxisW-1:0] ax_x = '0, ax_y = '0, ax_z = '0;
	logic [TimeW-1:0]        now_us = '0;
	int                      burst_left = 0;
	bit                      sender_idles = 1'b1;
	int                      phase_items = 0;
	int                      idle_cycles = 0;
	int                      stall_mode = 0;
	int                      stall_left = 0;

	double_knock_shake_gesture_detector_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.time_us(time_us), .cards_active(cards_active),
		.out_valid(out_valid), .out_stall(out_stall),
		.gesture(gesture), .motion(motion)
	);

	dksg_checker gesture_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.time_us(time_us), .cards_active(cards_active),
		.out_valid(out_valid), .out_stall(out_stall),
		.gesture(gesture), .motion(motion),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side stalls in segments: none, light, heavy, half
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(10, 150);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [DataW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrW'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SHAKE_BURST: cur_cfg.shake_burst_level = val[LevelW-1:0];
			REG_SHAKE_QUIET: cur_cfg.shake_quiet_level = val[LevelW-1:0];
			REG_KNOCK_BURST: cur_cfg.knock_burst_level = val[LevelW-1:0];
			REG_KNOCK_QUIET: cur_cfg.knock_quiet_level = val[LevelW-1:0];
			REG_COOLDOWN:    cur_cfg.cooldown_us = val[SpanW-1:0];
			REG_SHAKE_WIN:   cur_cfg.shake_window_us = val[SpanW-1:0];
			REG_KNOCK_GAP:   cur_cfg.knock_min_gap_us = val[SpanW-1:0];
			REG_KNOCK_WIN:   cur_cfg.knock_window_us = val[SpanW-1:0];
			default: ;
		endcase
	endtask

	task automatic load_thresholds(input logic [DataW-1:0] sb, sq, kb, kq, cd, sw, kg, kw);
		apb_write(REG_SHAKE_BURST, sb);
		apb_write(REG_SHAKE_QUIET, sq);
		apb_write(REG_KNOCK_BURST, kb);
		apb_write(REG_KNOCK_QUIET, kq);
		apb_write(REG_COOLDOWN, cd);
		apb_write(REG_SHAKE_WIN, sw);
		apb_write(REG_KNOCK_GAP, kg);
		apb_write(REG_KNOCK_WIN, kw);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_sample(input logic signed [AxisW-1:0] x, y, z,
			input logic [TimeW-1:0] t, input logic c);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (sender_idles) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6))
					@(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		time_us <= t;
		cards_active <= c;
		do @(posedge clk); while (in_stall);
		ax_x = x;
		ax_y = y;
		ax_z = z;
		now_us = t;
		phase_items++;
	endtask

	function automatic logic signed [AxisW-1:0] step_axis(logic signed [AxisW-1:0] p, int d);
		int v;
		v = (p >= 0) ? int'(p) - d : int'(p) + d;
		return AxisW'(v);
	endfunction

	// new sample whose summed axis change from the last one equals target
	task automatic send_level(input int target, input logic [TimeW-1:0] t, input logic c);
		int rem, dx, dy;
		rem = (target > MaxStep) ? MaxStep : target;
		dx = $urandom_range((rem > 65534) ? rem - 65534 : 0, (rem > 32767) ? 32767 : rem);
		rem -= dx;
		dy = $urandom_range((rem > 32767) ? rem - 32767 : 0, (rem > 32767) ? 32767 : rem);
		rem -= dy;
		push_sample(step_axis(ax_x, dx), step_axis(ax_y, dy), step_axis(ax_z, rem), t, c);
	endtask

	function automatic int burst_motion(int lvl, int span);
		int lo, hi;
		lo = (lvl > MaxStep) ? MaxStep : lvl;
		hi = (lo + span > MaxStep) ? MaxStep : lo + span;
		return $urandom_range(lo, hi);
	endfunction

	function automatic int quiet_motion(int lvl);
		if (lvl == 0)
			return 0;
		return $urandom_range(0, (lvl - 1 > MaxStep) ? MaxStep : lvl - 1);
	endfunction

	task automatic shake_pair();
		logic             c;
		logic [TimeW-1:0] t0, tq, ts;
		int               win, lo_b, span, q, slack, sq;
		c = 1'($urandom_range(0, 1));
		win = int'(cur_cfg.shake_window_us);
		lo_b = int'(cur_cfg.shake_burst_level);
		sq = int'(cur_cfg.shake_quiet_level);
		span = 20000;
		// in card mode keep the bursts under a higher knock level so the knock side stays idle
		if (c && int'(cur_cfg.knock_burst_level) > lo_b &&
				int'(cur_cfg.knock_burst_level) - 1 - lo_b < span)
			span = int'(cur_cfg.knock_burst_level) - 1 - lo_b;
		if ($urandom_range(0, 4) != 0)
			t0 = now_us + cur_cfg.cooldown_us + $urandom_range(1, 50000);
		else
			t0 = now_us + $urandom_range(1, 300000);
		send_level(burst_motion(lo_b, span), t0, c);
		q = $urandom_range(1, 100000);
		tq = t0 + q;
		if ($urandom_range(0, 3) == 0)
			send_level(burst_motion(lo_b, span), t0 + q / 2, c);
		send_level(quiet_motion(sq), tq, c);
		repeat ($urandom_range(0, 2))
			send_level(quiet_motion(sq), now_us + $urandom_range(1, 20000), c);
		slack = win - q - ShakeSecondGapUs;
		if (slack < 0)
			slack = 0;
		case ($urandom_range(0, 9))
			7: ts = tq + ShakeSecondGapUs - 1;
			8: ts = t0 + win;
			9: ts = t0 + win + 1;
			default: ts = tq + ShakeSecondGapUs + $urandom_range(0, slack);
		endcase
		send_level(burst_motion(lo_b, span), ts, c);
	endtask

	task automatic knock_pair();
		logic [TimeW-1:0] t0;
		int               kb, gap, win, q, lo, dt;
		kb = int'(cur_cfg.knock_burst_level);
		gap = int'(cur_cfg.knock_min_gap_us);
		win = int'(cur_cfg.knock_window_us);
		t0 = now_us + $urandom_range(1, 300000);
		send_level(burst_motion(kb, 20000), t0, 1'b1);
		q = $urandom_range(1, (gap > 100001) ? 100000 : ((gap > 1) ? gap - 1 : 1));
		// card mode now and then drops between the knocks
		send_level(quiet_motion(int'(cur_cfg.knock_quiet_level)), t0 + q,
			$urandom_range(0, 19) != 0);
		lo = (gap > q) ? gap : q + 1;
		case ($urandom_range(0, 9))
			7: dt = (gap > q + 1) ? gap - 1 : lo;
			8: dt = win;
			9: dt = win + 1;
			default: dt = (lo <= win) ? $urandom_range(lo, win) : lo;
		endcase
		send_level(burst_motion(kb, 20000), t0 + dt, 1'b1);
	endtask

	task automatic noise_run();
		logic [TimeW-1:0] t;
		logic             c;
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 9))
				0: t = TimeW'({$urandom, $urandom});
				1: t = {TimeW{1'b1}} - $urandom_range(0, 300000);
				default: t = now_us + $urandom_range(0, 200000);
			endcase
			c = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 1))
				push_sample(AxisW'($urandom), AxisW'($urandom), AxisW'($urandom), t, c);
			else
				send_level($urandom_range(0, 70000), t, c);
		end
	endtask

	task automatic run_phase(input int count, input bit idles);
		int pick;
		sender_idles = idles;
		burst_left = 0;
		phase_items = 0;
		while (phase_items < count) begin
			pick = $urandom_range(0, 19);
			if (pick < 9)
				shake_pair();
			else if (pick < 16)
				knock_pair();
			else
				noise_run();
		end
	endtask

	initial begin
		int sb, kb, kg;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_thresholds(ShakeBurstRst, ShakeQuietRst, KnockBurstRst, KnockQuietRst,
			CooldownRst, ShakeWinRst, KnockGapRst, KnockWinRst);

		// priming, full-swing motion, cooldown right after reset
		push_sample(-16'sd32768, -16'sd32768, -16'sd32768, 48'd0, 1'b0);
		push_sample(16'sd32767, 16'sd32767, 16'sd32767, 48'd10, 1'b0);
		push_sample(-16'sd32768, -16'sd32768, -16'sd32768, 48'd20, 1'b1);
		push_sample(-16'sd32768, -16'sd32768, -16'sd32768, 48'd30, 1'b0);
		// shake toggle, second burst too early then exactly at the gap
		send_level(30000, 48'd1000000, 1'b0);
		send_level(0, 48'd1050000, 1'b0);
		send_level(30000, 48'd1100000, 1'b0);
		send_level(30000, 48'd1170000, 1'b0);
		send_level(30000, 48'd1300000, 1'b0);
		// knock confirm, one short of the minimum gap first
		send_level(30000, 48'd2000000, 1'b1);
		send_level(100, 48'd2050000, 1'b1);
		send_level(30000, 48'd2099999, 1'b1);
		send_level(30000, 48'd2100000, 1'b1);
		// shake next in card mode, bursts below the knock level
		send_level(25000, 48'd2800000, 1'b1);
		send_level(0, 48'd2900000, 1'b1);
		send_level(25000, 48'd3020000, 1'b1);
		// knock pair runs out of window
		send_level(30000, 48'd4000000, 1'b1);
		send_level(0, 48'd4550001, 1'b1);
		// shake toggle across the timestamp wrap
		send_level(30000, 48'hFFFF_FFFF_0000, 1'b0);
		send_level(0, 48'hFFFF_FFFF_FFFF, 1'b0);
		send_level(30000, 48'h0000_0002_0000, 1'b0);

		run_phase(350, 1'b1);

		drain_results();
		load_thresholds('0, '0, '0, '0, '0, '0, '0, '0);
		run_phase(150, 1'b1);

		drain_results();
		load_thresholds('1, '1, '1, '1, '1, '1, '1, '1);
		run_phase(150, 1'b0);

		repeat (3) begin
			drain_results();
			sb = $urandom_range(15000, 40000);
			kb = $urandom_range(sb + 2000, 70000);
			kg = $urandom_range(0, 200000);
			load_thresholds(sb, $urandom_range(2000, 14000), kb, $urandom_range(2000, 15000),
				$urandom_range(0, 800000), $urandom_range(150000, 2000000), kg,
				$urandom_range(kg + 50000, 800000));
			run_phase(300, 1'($urandom_range(0, 1)));
		end

		drain_results();
		load_thresholds($urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
		run_phase(150, 1'b1);

		drain_results();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
